// ===== src/c2d_pkg.sv =====
// Shared types and constants for the direct convolution block.
package c2d_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_LOAD_ACT = 2'd0;
    localparam logic [1:0] CMD_LOAD_WGT = 2'd1;
    localparam logic [1:0] CMD_COMPUTE  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_CHANNELS_IN   = 3'd0;
    localparam logic [2:0] REG_HEIGHT_IN     = 3'd1;
    localparam logic [2:0] REG_WIDTH_IN      = 3'd2;
    localparam logic [2:0] REG_CHANNELS_OUT  = 3'd3;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd4;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd5;
    localparam logic [2:0] REG_STRIDE        = 3'd6;
    localparam logic [2:0] REG_PADDING       = 3'd7;

    // Store geometry and output limits.
    localparam int ACT_AW           = 16;
    localparam int WGT_AW           = 14;
    localparam int MAX_CHANNELS_OUT = 16;
    localparam int MAX_OUT_DIM      = 128;

    typedef logic signed [39:0] acc_t;

endpackage

// ===== src/conv2d_direct_mac.sv =====
// Direct 2D convolution over one NCHW image with stride and zero padding.
// A load item writes its value to the activation or weight store. A compute item runs setup,
// eight division steps and position, then the address, read, multiply and accumulate sequence
// around the two store ports for every kernel tap, counting padded taps (channels_in *
// kernel_height * kernel_width), and then finish; an invalid configuration skips to finish.
// A finished result waits in the output register while loads are accepted.
// Reset (rst_n, asynchronous) restores the configuration defaults and the
// position; the activation and weight stores are not cleared.
module conv2d_direct_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [15:0]         addr,
    input  logic signed [15:0]  data_value,
    output logic                out_valid,
    input  logic                out_stall,
    output c2d_pkg::acc_t       out_value,
    output logic [3:0]          out_chan,
    output logic [6:0]          out_row,
    output logic [6:0]          out_col,
    output logic                status,
    output logic                last
);
    import c2d_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_POS  = 4'd2;
    localparam logic [3:0] S_A1   = 4'd3;
    localparam logic [3:0] S_A2   = 4'd4;
    localparam logic [3:0] S_A3   = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_PRE  = 4'd10;

    // Configuration registers.
    logic [4:0] cin_reg, cout_reg;
    logic [6:0] hin_reg, win_reg;
    logic [3:0] kh_reg, kw_reg;
    logic [7:0] stride_reg;
    logic [5:0] pad_reg;

    // Control state.
    logic [3:0] state_reg;
    logic [3:0] co_reg;
    logic [6:0] oy_reg, ox_reg;
    logic [4:0] ci_reg;
    logic [3:0] ky_reg, kx_reg;
    logic [2:0] div_cnt_reg;
    logic       bad_reg;
    logic       out_valid_reg;

    // Datapath registers.
    logic [7:0]  num_v_reg, num_h_reg, q_v_reg, q_h_reg;
    logic [3:0]  rem_v_reg, rem_h_reg;
    logic [7:0]  hout_reg, wout_reg;
    logic [4:0]  coutn_reg;
    logic signed [12:0] y0_reg, x0_reg;
    logic [15:0] t1_reg, ai_reg;
    logic [6:0]  ix_reg;
    logic [13:0] wt1_reg, wt2_reg, wi_reg;
    logic        inb_reg;
    logic signed [15:0] act_q_reg, wgt_q_reg;
    logic signed [31:0] prod_reg;
    acc_t        acc_reg;
    acc_t        out_value_reg;
    logic [3:0]  out_chan_reg;
    logic [6:0]  out_row_reg, out_col_reg;
    logic        status_reg, last_reg;

    logic [15:0] act_mem [0:(1 << ACT_AW) - 1];
    logic [15:0] wgt_mem [0:(1 << WGT_AW) - 1];

    logic       in_accept, out_free;
    logic [3:0] sv, sh;
    logic [2:0] pv, ph;
    logic [7:0] span_v, span_h;
    logic       short_v, short_h;
    logic [4:0] trial_v, trial_h;
    logic [8:0] dv_full, dh_full;
    logic [7:0] hout_cur, wout_cur;
    logic [4:0] coutn;
    logic       stale;
    logic signed [12:0] iy, ix;
    logic       kx_end, ky_end, ci_end;
    logic       is_last;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign sv = stride_reg[3:0];
    assign sh = stride_reg[7:4];
    assign pv = pad_reg[2:0];
    assign ph = pad_reg[5:3];
    assign span_v  = {1'b0, hin_reg} + {4'd0, pv, 1'b0};
    assign span_h  = {1'b0, win_reg} + {4'd0, ph, 1'b0};
    assign short_v = span_v < {4'd0, kh_reg};
    assign short_h = span_h < {4'd0, kw_reg};
    assign coutn   = (cout_reg > 5'(MAX_CHANNELS_OUT)) ? 5'(MAX_CHANNELS_OUT) : cout_reg;

    // One restoring division step per cycle for each output dimension.
    assign trial_v = {rem_v_reg, num_v_reg[7]};
    assign trial_h = {rem_h_reg, num_h_reg[7]};
    assign dv_full = {1'b0, q_v_reg} + 9'd1;
    assign dh_full = {1'b0, q_h_reg} + 9'd1;

    // Output size of the current configuration, valid in the position step.
    assign hout_cur = (dv_full > 9'(MAX_OUT_DIM)) ? 8'(MAX_OUT_DIM) : dv_full[7:0];
    assign wout_cur = (dh_full > 9'(MAX_OUT_DIM)) ? 8'(MAX_OUT_DIM) : dh_full[7:0];

    assign stale = ({1'b0, co_reg} >= coutn_reg) || ({1'b0, oy_reg} >= hout_cur)
                || ({1'b0, ox_reg} >= wout_cur);

    assign iy = y0_reg + $signed({9'd0, ky_reg});
    assign ix = x0_reg + $signed({9'd0, kx_reg});

    assign kx_end = ({1'b0, kx_reg} + 5'd1) == {1'b0, kw_reg};
    assign ky_end = ({1'b0, ky_reg} + 5'd1) == {1'b0, kh_reg};
    assign ci_end = ({1'b0, ci_reg} + 6'd1) == {1'b0, cin_reg};

    assign is_last = ({1'b0, co_reg} == coutn_reg - 5'd1)
                  && ({1'b0, oy_reg} == hout_reg - 8'd1)
                  && ({1'b0, ox_reg} == wout_reg - 8'd1);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cin_reg    <= 5'd1;
            hin_reg    <= 7'd1;
            win_reg    <= 7'd1;
            cout_reg   <= 5'd1;
            kh_reg     <= 4'd1;
            kw_reg     <= 4'd1;
            stride_reg <= 8'h11;
            pad_reg    <= 6'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CHANNELS_IN:   cin_reg    <= cfg_data[4:0];
                REG_HEIGHT_IN:     hin_reg    <= cfg_data[6:0];
                REG_WIDTH_IN:      win_reg    <= cfg_data[6:0];
                REG_CHANNELS_OUT:  cout_reg   <= cfg_data[4:0];
                REG_KERNEL_HEIGHT: kh_reg     <= cfg_data[3:0];
                REG_KERNEL_WIDTH:  kw_reg     <= cfg_data[3:0];
                REG_STRIDE:        stride_reg <= cfg_data;
                REG_PADDING:       pad_reg    <= cfg_data[5:0];
                default:           pad_reg    <= pad_reg;
            endcase
        end
    end

    // Activation store: written by loads, read once per tap.
    always_ff @(posedge clk)
    begin
        if (in_accept && cmd == CMD_LOAD_ACT)
            act_mem[addr] <= data_value;
        if (state_reg == S_RD)
            act_q_reg <= act_mem[ai_reg];
    end

    // Weight store: written by loads, read once per tap.
    always_ff @(posedge clk)
    begin
        if (in_accept && cmd == CMD_LOAD_WGT)
            wgt_mem[addr[WGT_AW-1:0]] <= data_value;
        if (state_reg == S_RD)
            wgt_q_reg <= wgt_mem[wi_reg];
    end

    // Sequencer control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            co_reg        <= 4'd0;
            oy_reg        <= 7'd0;
            ox_reg        <= 7'd0;
            ci_reg        <= 5'd0;
            ky_reg        <= 4'd0;
            kx_reg        <= 4'd0;
            div_cnt_reg   <= 3'd0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && cmd == CMD_COMPUTE)
                        state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    bad_reg     <= (sv == 4'd0) || (sh == 4'd0) || short_v || short_h
                                || (coutn == 5'd0);
                    div_cnt_reg <= 3'd0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (bad_reg)
                        state_reg <= S_FIN;
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + 3'd1;
                        if (div_cnt_reg == 3'd7)
                            state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    if (stale)
                    begin
                        co_reg <= 4'd0;
                        oy_reg <= 7'd0;
                        ox_reg <= 7'd0;
                    end
                    ci_reg <= 5'd0;
                    ky_reg <= 4'd0;
                    kx_reg <= 4'd0;
                    if (cin_reg == 5'd0 || kh_reg == 4'd0 || kw_reg == 4'd0)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_A1;
                end
                S_A1:  state_reg <= S_A2;
                S_A2:  state_reg <= S_A3;
                S_A3:  state_reg <= S_RD;
                S_RD:  state_reg <= S_MUL;
                S_MUL: state_reg <= S_ACC;
                S_ACC:
                begin
                    state_reg <= S_A1;
                    if (!kx_end)
                        kx_reg <= kx_reg + 4'd1;
                    else
                    begin
                        kx_reg <= 4'd0;
                        if (!ky_end)
                            ky_reg <= ky_reg + 4'd1;
                        else
                        begin
                            ky_reg <= 4'd0;
                            ci_reg <= ci_reg + 5'd1;
                            if (ci_end)
                                state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (!bad_reg)
                        begin
                            if ({1'b0, ox_reg} + 8'd1 < wout_reg)
                                ox_reg <= ox_reg + 7'd1;
                            else
                            begin
                                ox_reg <= 7'd0;
                                if ({1'b0, oy_reg} + 8'd1 < hout_reg)
                                    oy_reg <= oy_reg + 7'd1;
                                else
                                begin
                                    oy_reg <= 7'd0;
                                    if ({1'b0, co_reg} + 5'd1 < coutn_reg)
                                        co_reg <= co_reg + 4'd1;
                                    else
                                        co_reg <= 4'd0;
                                end
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath: output size, addresses, multiply and accumulate.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_PRE:
            begin
                num_v_reg <= span_v - {4'd0, kh_reg};
                num_h_reg <= span_h - {4'd0, kw_reg};
                rem_v_reg <= 4'd0;
                rem_h_reg <= 4'd0;
                q_v_reg   <= 8'd0;
                q_h_reg   <= 8'd0;
                coutn_reg <= coutn;
            end
            S_DIV:
            begin
                num_v_reg <= {num_v_reg[6:0], 1'b0};
                num_h_reg <= {num_h_reg[6:0], 1'b0};
                if (trial_v >= {1'b0, sv})
                begin
                    rem_v_reg <= 4'(trial_v - {1'b0, sv});
                    q_v_reg   <= {q_v_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_v_reg <= trial_v[3:0];
                    q_v_reg   <= {q_v_reg[6:0], 1'b0};
                end
                if (trial_h >= {1'b0, sh})
                begin
                    rem_h_reg <= 4'(trial_h - {1'b0, sh});
                    q_h_reg   <= {q_h_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_h_reg <= trial_h[3:0];
                    q_h_reg   <= {q_h_reg[6:0], 1'b0};
                end
            end
            S_POS:
            begin
                hout_reg <= hout_cur;
                wout_reg <= wout_cur;
                acc_reg  <= '0;
            end
            S_A1:
            begin
                inb_reg <= !iy[12] && (iy[11:0] < {5'd0, hin_reg})
                        && !ix[12] && (ix[11:0] < {5'd0, win_reg});
                t1_reg  <= 16'(ci_reg * hin_reg) + {4'd0, iy[11:0]};
                ix_reg  <= ix[6:0];
                wt1_reg <= 14'(co_reg * cin_reg) + {9'd0, ci_reg};
            end
            S_A2:
            begin
                ai_reg  <= 16'(t1_reg * win_reg) + {9'd0, ix_reg};
                wt2_reg <= 14'(wt1_reg * kh_reg) + {10'd0, ky_reg};
            end
            S_A3:
            begin
                wi_reg <= 14'(wt2_reg * kw_reg) + {10'd0, kx_reg};
            end
            S_MUL:
            begin
                prod_reg <= act_q_reg * wgt_q_reg;
            end
            S_ACC:
            begin
                if (inb_reg)
                    acc_reg <= acc_reg + acc_t'(prod_reg);
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
        // Tap origin follows the position chosen in the position step.
        if (state_reg == S_POS)
        begin
            if (stale)
            begin
                y0_reg <= -$signed({10'd0, pv});
                x0_reg <= -$signed({10'd0, ph});
            end
            else
            begin
                y0_reg <= $signed({2'd0, 11'(oy_reg * sv)}) - $signed({10'd0, pv});
                x0_reg <= $signed({2'd0, 11'(ox_reg * sh)}) - $signed({10'd0, ph});
            end
        end
        // Result register loads when the slot is free.
        if (state_reg == S_FIN && out_free)
        begin
            if (bad_reg)
            begin
                out_value_reg <= '0;
                out_chan_reg  <= 4'd0;
                out_row_reg   <= 7'd0;
                out_col_reg   <= 7'd0;
                status_reg    <= 1'b1;
                last_reg      <= 1'b0;
            end
            else
            begin
                out_value_reg <= acc_reg;
                out_chan_reg  <= co_reg;
                out_row_reg   <= oy_reg;
                out_col_reg   <= ox_reg;
                status_reg    <= 1'b0;
                last_reg      <= is_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_chan  = out_chan_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign status    = status_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // An error result carries no sum and never marks the last pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> out_value == '0 && !last)
        else $error("error result carries data");

    // No item is taken while a compute item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken during compute");

    // A finished pixel waits while the result slot is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && !out_free |=> state_reg == S_FIN)
        else $error("result overwritten");

    // A new result appears only after the finish step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_FIN)
        else $error("result without finish step");
`endif

endmodule
